[sv/spmd_pkg.sv]
`timescale 1ns / 1ps

package spmd_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_IGNORE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_ENTRY    = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef logic [4:0] fill_t;

    typedef struct packed {
        func_t       func;
        logic [7:0]  term_index;
        logic [3:0]  num_errors;
        logic        special;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  out_term_index;
        logic [3:0]  out_num_errors;
        logic        out_special;
        fill_t       fill;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  term;
        logic [3:0]  errors;
        logic        special;
    } entry_t;

    typedef struct packed {
        logic        insert;
        logic        rotate;
        logic        mode;
    } cell_ctl_t;

endpackage

[sv/spmd_cell.sv]
`timescale 1ns / 1ps

module spmd_cell (
    input  logic                aclk,
    input  spmd_pkg::cell_ctl_t ctl,
    input  spmd_pkg::entry_t    new_entry,
    input  spmd_pkg::entry_t    prev_entry,
    input  spmd_pkg::entry_t    next_entry,
    input  spmd_pkg::entry_t    wrap_entry,
    input  logic                occupied,
    input  logic                is_last,
    input  logic                stopped_in,
    output logic                stopped_out,
    output logic                dup,
    output spmd_pkg::entry_t    entry
);
    import spmd_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   ahead;
    logic   same;
    logic   at;

    always_comb begin
        ahead = (new_entry.errors < entry_reg.errors) ||
                ((new_entry.errors == entry_reg.errors) &&
                 ((new_entry.term < entry_reg.term) ||
                  (ctl.mode && (new_entry.term == entry_reg.term) &&
                   !new_entry.special && entry_reg.special)));
        same = (new_entry.term == entry_reg.term) &&
               (new_entry.errors == entry_reg.errors) &&
               (!ctl.mode || (new_entry.special == entry_reg.special));
    end

    assign at          = !stopped_in && !(occupied && ahead);
    assign stopped_out = stopped_in || at;
    assign dup         = at && occupied && same;
    assign entry       = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        priority if (ctl.insert) begin
            if (at) begin
                entry_next = new_entry;
            end else if (stopped_in) begin
                entry_next = prev_entry;
            end
        end else if (ctl.rotate && occupied) begin
            entry_next = is_last ? wrap_entry : next_entry;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

[sv/sorted_position_merge_dedup.sv]
`timescale 1ns / 1ps
// clear, insert and empty read reply from a register; a read first enters S_READ
// all cells compare the new entry in parallel
// read out gives one entry per cycle from the front cell unless stalled; occupied cells rotate
// a read holds the input until its last entry; other items follow back to back unless stalled
// synchronous active-low reset empties the list and sets standard mode

module sorted_position_merge_dedup #(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  spmd_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output spmd_pkg::out_item_t m_data
);
    import spmd_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              mode_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    cell_ctl_t         ctl;
    entry_t            new_entry;
    entry_t            cell_entry [DEPTH];
    logic [DEPTH-1:0]  occupied;
    logic [DEPTH-1:0]  is_last;
    logic [DEPTH:0]    stopped;
    logic [DEPTH-1:0]  dup;
    logic              out_free;
    logic              accept;
    logic              dup_any;
    logic              full;
    logic              rd_last;
    logic [CNT_W-1:0]  count_plus;

    function automatic out_item_t status_item(status_t st, fill_t f);
        out_item_t r;
        r        = '0;
        r.status = st;
        r.fill   = f;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic out_item_t entry_item(entry_t e, fill_t f, logic lst);
        out_item_t r;
        r                = '0;
        r.status         = ST_ENTRY;
        r.out_term_index = e.term;
        r.out_num_errors = e.errors;
        r.out_special    = e.special;
        r.fill           = f;
        r.last           = lst;
        return r;
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign dup_any   = |dup;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign rd_last   = (rd_idx_reg == count_reg - CNT_W'(1));
    assign count_plus = count_reg + CNT_W'(1);

    assign new_entry.term    = s_data.term_index;
    assign new_entry.errors  = s_data.num_errors;
    assign new_entry.special = s_data.special;

    assign ctl.insert = accept && (s_data.func == FUNC_INSERT) && !dup_any && !full;
    assign ctl.rotate = (state_reg == S_READ) && out_free;
    assign ctl.mode   = mode_reg;

    assign stopped[0] = 1'b0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        assign occupied[k] = CNT_W'(k) < count_reg;
        assign is_last[k]  = CNT_W'(k + 1) == count_reg;

        spmd_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .prev_entry  ((k == 0) ? new_entry : cell_entry[(k == 0) ? 0 : k - 1]),
            .next_entry  ((k == DEPTH - 1) ? cell_entry[0]
                                           : cell_entry[(k == DEPTH - 1) ? 0 : k + 1]),
            .wrap_entry  (cell_entry[0]),
            .occupied    (occupied[k]),
            .is_last     (is_last[k]),
            .stopped_in  (stopped[k]),
            .stopped_out (stopped[k+1]),
            .dup         (dup[k]),
            .entry       (cell_entry[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        unique case (s_data.func)
                            FUNC_CLEAR: begin
                                count_reg   <= '0;
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= status_item(ST_CLEARED, '0);
                            end
                            FUNC_INSERT: begin
                                m_valid_reg <= 1'b1;
                                priority if (dup_any) begin
                                    m_data_reg <= status_item(ST_DUP, fill_t'(count_reg));
                                end else if (full) begin
                                    m_data_reg <= status_item(ST_FULL, fill_t'(count_reg));
                                end else begin
                                    m_data_reg <= status_item(ST_INSERTED,
                                                              fill_t'(count_plus));
                                    count_reg  <= count_plus;
                                end
                            end
                            FUNC_READ: begin
                                if (count_reg == '0) begin
                                    m_valid_reg <= 1'b1;
                                    m_data_reg  <= status_item(ST_EMPTY, '0);
                                end else begin
                                    m_valid_reg <= 1'b0;
                                    state_reg   <= S_READ;
                                    rd_idx_reg  <= '0;
                                end
                            end
                            FUNC_IGNORE: begin
                                m_valid_reg <= 1'b0;
                            end
                            default: begin
                                m_valid_reg <= 1'b0;
                            end
                        endcase
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= entry_item(cell_entry[0], fill_t'(count_reg), rd_last);
                        rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
                        if (rd_last) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("list count above depth");

    property p_refused_keeps_count;
        @(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.func == FUNC_INSERT) && (dup_any || full))
            |=> $stable(count_reg);
    endproperty
    a_refused_keeps_count: assert property (p_refused_keeps_count)
        else $error("refused insert changed the count");

    property p_clear_empties;
        @(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.func == FUNC_CLEAR)) |=> (count_reg == '0);
    endproperty
    a_clear_empties: assert property (p_clear_empties)
        else $error("clear left entries");

    property p_read_no_accept;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !s_ready && !ctl.insert;
    endproperty
    a_read_no_accept: assert property (p_read_no_accept)
        else $error("item taken during read out");

endmodule
